// ===== hdl/bam_pkg.sv =====
package bam_pkg;

  localparam int unsigned SUM_W = 24;
  localparam int unsigned CNT_W = 17;
  localparam int unsigned CFG_W = 9;
  localparam int unsigned COORD_W = 8;

  localparam logic [1:0] REG_BLOCK_SIZE = 2'd0;
  localparam logic [1:0] REG_TILE_WIDTH = 2'd1;
  localparam logic [1:0] REG_TILE_HEIGHT = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIVX,
    ST_DIVY,
    ST_READ,
    ST_UPD,
    ST_MEAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr_init;
    logic clr_step;
    logic load;
    logic div_step;
    logic div_y_start;
    logic rd;
    logic wr;
    logic mean_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic outside;
    logic emit;
    logic mean_done;
  } sts_t;

endpackage

// ===== hdl/block_average_mosaic_top.sv =====
// channel | dir | ports                  | word
// in      | in  | in_tvalid/tready/tdata | x, y, blue, green, red
// out     | out | out_tvalid/tready/tdata/tlast | column, row, color; last_block
// cfg     | in  | cfg_tvalid/tready/index/data  | register write
// Per pixel: accept, two 8-bit coordinate divisions in one shared restoring
// divider, memory read, write; a pixel outside the tile skips the read and write.
// A block's last pixel adds three 25-bit mean divisions in the same divider and
// a load of the output register.
// After reset a clearing pass of MAX_TILE_EDGE words (capped at 256) zeroes the
// column memories; no pixel is taken meanwhile. The output register frees the
// datapath while a result waits; a second result stalls until it drains.
module block_average_mosaic_top #(
  parameter int unsigned MAX_TILE_EDGE = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // pixel_x, pixel_y, blue, green, red
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // block_column, block_row, average_color
  output logic        out_tlast,
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import bam_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_tready = 1'b1;

  bam_ctrl u_ctrl (.clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .sts, .cmd);

  bam_dp #(.MAX_TILE_EDGE(MAX_TILE_EDGE)) u_dp (.clk, .rst_n, .cfg_tvalid, .cfg_index,
    .cfg_data, .in_tdata, .cmd, .sts, .out_tdata, .out_tlast);
endmodule

// ===== hdl/bam_ram.sv =====
module bam_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/bam_ctrl.sv =====
module bam_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  bam_pkg::sts_t sts,
  output bam_pkg::cmd_t cmd
);
  import bam_pkg::*;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clr_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_DIVX;
      ST_DIVX:  if (sts.div_done) state_nxt = ST_DIVY;
      ST_DIVY:  if (sts.div_done) state_nxt = sts.outside ? ST_IDLE : ST_READ;
      ST_READ:  state_nxt = ST_UPD;
      ST_UPD:   state_nxt = sts.emit ? ST_MEAN : ST_IDLE;
      ST_MEAN:  if (sts.mean_done) state_nxt = ST_EMIT;
      ST_EMIT:  if (!ovalid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    ovalid_nxt = ovalid_r && !out_tready;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_DIVX: begin
        cmd.div_step = 1'b1;
        cmd.div_y_start = sts.div_done;
      end
      ST_DIVY:  cmd.div_step = 1'b1;
      ST_READ:  cmd.rd = 1'b1;
      ST_UPD: begin
        cmd.wr = 1'b1;
        cmd.mean_start = sts.emit;
      end
      ST_MEAN:  cmd.div_step = 1'b1;
      ST_EMIT: begin
        if (!ovalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          ovalid_nxt = 1'b1;
        end
      end
      default: cmd.clr_init = 1'b1;
    endcase
  end

  assign out_tvalid = ovalid_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_tready)
    else $error("input taken during clear");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("result overwritten");
endmodule

// ===== hdl/bam_dp.sv =====
module bam_dp #(
  parameter int unsigned MAX_TILE_EDGE = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_tvalid,
  input  logic [1:0]                     cfg_index,
  input  logic [bam_pkg::CFG_W-1:0]      cfg_data,
  input  logic [39:0]                    in_tdata,
  input  bam_pkg::cmd_t                  cmd,
  output bam_pkg::sts_t                  sts,
  output logic [39:0]                    out_tdata,
  output logic                           out_tlast
);
  import bam_pkg::*;

  localparam int unsigned CAPV = (MAX_TILE_EDGE < 256) ? MAX_TILE_EDGE : 256;
  localparam int unsigned AW = $clog2(CAPV);
  localparam int unsigned DQ_W = SUM_W + 1;

  logic [CFG_W-1:0] bs_r, tw_r, th_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r <= CFG_W'(8);
      tw_r <= CFG_W'(256);
      th_r <= CFG_W'(256);
    end else if (cfg_tvalid) begin
      unique case (cfg_index)
        REG_BLOCK_SIZE:  bs_r <= cfg_data;
        REG_TILE_WIDTH:  tw_r <= cfg_data;
        REG_TILE_HEIGHT: th_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [CFG_W-1:0] clampe(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] t;
    t = (v == '0) ? CFG_W'(1) : v;
    return (t > CFG_W'(CAPV)) ? CFG_W'(CAPV) : t;
  endfunction

  logic [CFG_W-1:0] bs, w, h;
  assign bs = (bs_r == '0) ? CFG_W'(1) : bs_r;
  assign w  = clampe(tw_r);
  assign h  = clampe(th_r);

  logic [7:0] x_r, y_r, b_r, g_r, r_r;
  logic [7:0] col_r, row_r;

  // shared restoring divider: 8-bit quotient by coordinate, 25-bit for means
  logic [DQ_W-1:0]  dq_r;
  logic [CNT_W:0]   drem_r;
  logic [CNT_W-1:0] dd_r;
  logic [4:0]       dcnt_r;
  logic [1:0]       dch_r;
  logic [7:0]       mean_r [3];
  logic [SUM_W-1:0] sg_r, sb_r;
  logic [CNT_W-1:0] cn_r;
  logic             mean_mode_r;

  logic [CNT_W:0]   dtry;
  logic             dge;
  assign dtry = {drem_r[CNT_W-1:0], dq_r[DQ_W-1]};
  assign dge  = dtry >= {1'b0, dd_r};

  logic [4:0] dlast;
  assign dlast = mean_mode_r ? 5'(DQ_W - 1) : 5'd7;
  assign sts.div_done = dcnt_r == dlast;

  logic [DQ_W-1:0] qfin;
  assign qfin = {dq_r[DQ_W-2:0], dge};

  logic [AW-1:0] clr_a_r;
  logic          clr_busy_r;
  logic [SUM_W-1:0] rd_r, rd_g, rd_b;
  logic [CNT_W-1:0] rd_c;
  logic [SUM_W-1:0] nr, ng, nb;
  logic [CNT_W-1:0] nc;
  logic             emit_r;

  function automatic logic [SUM_W-1:0] sadd(input logic [SUM_W-1:0] a, input logic [7:0] v);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(v);
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  logic [CFG_W:0] xe, ye;
  logic [CFG_W-1:0] xend, yend;
  assign xe = ({2'b0, col_r} + 10'd1) * 10'(bs) > 10'(w) ? 10'(w)
            : 10'(({2'b0, col_r} + 10'd1) * 10'(bs));
  assign ye = ({2'b0, row_r} + 10'd1) * 10'(bs) > 10'(h) ? 10'(h)
            : 10'(({2'b0, row_r} + 10'd1) * 10'(bs));
  assign xend = xe[CFG_W-1:0];
  assign yend = ye[CFG_W-1:0];

  logic emit_now;
  assign emit_now = ({1'b0, x_r} == xend - CFG_W'(1)) && ({1'b0, y_r} == yend - CFG_W'(1));
  assign sts.emit = emit_now;

  assign nr = sadd(rd_r, r_r);
  assign ng = sadd(rd_g, g_r);
  assign nb = sadd(rd_b, b_r);
  assign nc = (rd_c == '1) ? rd_c : rd_c + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b_r <= in_tdata[23:16];
      g_r <= in_tdata[31:24];
      r_r <= in_tdata[39:32];
      x_r <= in_tdata[7:0];
      y_r <= in_tdata[15:8];
      mean_mode_r <= 1'b0;
      dq_r <= {in_tdata[7:0], {(DQ_W-8){1'b0}}};
      drem_r <= '0;
      dd_r <= CNT_W'(bs);
      dcnt_r <= '0;
    end else if (cmd.mean_start) begin
      sg_r <= ng;
      sb_r <= nb;
      cn_r <= nc;
      mean_mode_r <= 1'b1;
      dch_r <= 2'd0;
      dq_r <= {1'b0, nr} + DQ_W'(nc >> 1);
      drem_r <= '0;
      dd_r <= nc;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      if (!sts.div_done) begin
        dq_r   <= qfin;
        drem_r <= dge ? dtry - {1'b0, dd_r} : dtry;
        dcnt_r <= dcnt_r + 5'd1;
      end else begin
        drem_r <= '0;
        dcnt_r <= '0;
        if (!mean_mode_r) begin
          if (cmd.div_y_start) begin
            col_r <= qfin[7:0];
            dq_r  <= {y_r, {(DQ_W-8){1'b0}}};
          end else begin
            row_r <= qfin[7:0];
          end
        end else begin
          mean_r[dch_r] <= (qfin > DQ_W'(255)) ? 8'hFF : qfin[7:0];
          dch_r <= dch_r + 2'd1;
          dq_r  <= {1'b0, (dch_r == 2'd0 ? sg_r : sb_r)} + DQ_W'(cn_r >> 1);
        end
      end
    end
  end

  assign sts.outside = ({1'b0, x_r} >= w) || ({1'b0, y_r} >= h);
  assign sts.mean_done = mean_mode_r && sts.div_done && dch_r == 2'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_a_r <= '0;
      clr_busy_r <= 1'b1;
    end else if (cmd.clr_step) begin
      clr_a_r <= clr_a_r + AW'(1);
      if (clr_a_r == AW'(CAPV - 1)) clr_busy_r <= 1'b0;
    end
  end
  assign sts.clr_done = !clr_busy_r || (clr_a_r == AW'(CAPV - 1));

  logic          we;
  logic [AW-1:0] wa;
  assign we = cmd.clr_step || cmd.wr;
  assign wa = cmd.clr_step ? clr_a_r : col_r[AW-1:0];

  bam_ram #(.WIDTH(SUM_W), .DEPTH(CAPV)) u_r (.clk, .we, .waddr(wa),
    .wdata(cmd.clr_step || emit_now ? '0 : nr), .raddr(col_r[AW-1:0]), .rdata(rd_r));
  bam_ram #(.WIDTH(SUM_W), .DEPTH(CAPV)) u_g (.clk, .we, .waddr(wa),
    .wdata(cmd.clr_step || emit_now ? '0 : ng), .raddr(col_r[AW-1:0]), .rdata(rd_g));
  bam_ram #(.WIDTH(SUM_W), .DEPTH(CAPV)) u_b (.clk, .we, .waddr(wa),
    .wdata(cmd.clr_step || emit_now ? '0 : nb), .raddr(col_r[AW-1:0]), .rdata(rd_b));
  bam_ram #(.WIDTH(CNT_W), .DEPTH(CAPV)) u_c (.clk, .we, .waddr(wa),
    .wdata(cmd.clr_step || emit_now ? '0 : nc), .raddr(col_r[AW-1:0]), .rdata(rd_c));

  always_ff @(posedge clk) begin
    if (cmd.wr) emit_r <= ({1'b0, x_r} == w - CFG_W'(1)) && ({1'b0, y_r} == h - CFG_W'(1));
    if (cmd.out_load) begin
      out_tdata <= {mean_r[0], mean_r[1], mean_r[2], row_r, col_r};
      out_tlast <= emit_r;
    end
  end

  logic unused;
  assign unused = cmd.clr_init ^ cmd.rd;
endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bam_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] y;
    logic [7:0] x;
  } pixel_t;

  typedef struct {
    logic [7:0]  col;
    logic [7:0]  row;
    logic [23:0] color;
    logic        last;
  } block_mean_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [39:0] out_tdata;
  logic out_tlast;
  logic cfg_tvalid = 0;
  logic cfg_tready;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  block_average_mosaic_top dut (.*);

  initial forever #5 clk = ~clk;

  // shadow state
  int unsigned blk_edge, tw, th;
  int unsigned sum_r[256], sum_g[256], sum_b[256], px_cnt[256];

  pixel_t pixel_q[$];
  block_mean_t mean_q[$];
  int errors = 0;
  int n_pix = 0, n_blocks = 0, n_last = 0, n_out = 0;
  int hold_off = 0;
  bit stall_go = 0;
  int idle_cycles = 0;
  bit tb_done = 0;

  function automatic int unsigned sat(int unsigned a, int unsigned cap);
    return a > cap ? cap : a;
  endfunction

  function automatic int unsigned mean8(int unsigned s, int unsigned c);
    int unsigned m;
    if (c == 0) return 0;
    m = (s + c / 2) / c;
    return m > 255 ? 255 : m;
  endfunction

  function automatic int unsigned eff_edge(int unsigned v);
    if (v == 0) return 1;
    return v > 256 ? 256 : v;
  endfunction

  function automatic void enq_pixel(pixel_t p);
    pixel_q.insert(pixel_q.size(), p);
  endfunction

  task automatic predict_block(pixel_t p);
    int unsigned bs, w, h, c, r, xe, ye, cnt, mr, mg, mb;
    block_mean_t m;
    bs = blk_edge == 0 ? 1 : blk_edge;
    w = eff_edge(tw);
    h = eff_edge(th);
    if (p.x >= w || p.y >= h) return;
    c = p.x / bs;
    r = p.y / bs;
    sum_r[c] = sat(sum_r[c] + p.red, 24'hFFFFFF);
    sum_g[c] = sat(sum_g[c] + p.green, 24'hFFFFFF);
    sum_b[c] = sat(sum_b[c] + p.blue, 24'hFFFFFF);
    px_cnt[c] = sat(px_cnt[c] + 1, 17'h1FFFF);
    xe = (c + 1) * bs;
    if (xe > w) xe = w;
    ye = (r + 1) * bs;
    if (ye > h) ye = h;
    if (p.x != xe - 1 || p.y != ye - 1) return;
    cnt = px_cnt[c];
    mr = mean8(sum_r[c], cnt);
    mg = mean8(sum_g[c], cnt);
    mb = mean8(sum_b[c], cnt);
    m.col = c[7:0];
    m.row = r[7:0];
    m.color = {mr[7:0], mg[7:0], mb[7:0]};
    m.last = (p.x == w - 1 && p.y == h - 1);
    sum_r[c] = 0;
    sum_g[c] = 0;
    sum_b[c] = 0;
    px_cnt[c] = 0;
    mean_q.insert(mean_q.size(), m);
  endtask

  // input acceptance
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_block(pixel_t'(in_tdata));
      n_pix++;
    end
  end

  // driver
  int in_gap = 0;
  int n_sent = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (n_sent != n_pix) begin
        n_sent = n_pix;
        pixel_q.delete(0);
        in_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 11) : 0;
        in_tvalid <= 0;
      end else if (!in_tvalid && pixel_q.size() != 0) begin
        if (in_gap > 0) in_gap--;
        else begin
          in_tdata <= pixel_q[0];
          in_tvalid <= 1;
        end
      end
    end
  end

  // monitor
  int out_gap = 0;
  int out_seen = 0;
  bit stall_used = 0;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      block_mean_t e;
      n_out++;
      if (mean_q.size() == 0) begin
        $error("unexpected block: tdata %h tlast %b", out_tdata, out_tlast);
        errors++;
      end else begin
        e = mean_q.pop_front();
        n_blocks++;
        if (e.last) n_last++;
        if (out_tdata[7:0] !== e.col) begin
          $error("block_column exp %0d got %0d", e.col, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[15:8] !== e.row) begin
          $error("block_row exp %0d got %0d", e.row, out_tdata[15:8]);
          errors++;
        end
        if (out_tdata[39:16] !== e.color) begin
          $error("average_color exp %h got %h", e.color, out_tdata[39:16]);
          errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last_block exp %b got %b", e.last, out_tlast);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_tready <= 0;
    else if (stall_go && !stall_used) begin
      stall_used = 1;
      hold_off = 400;
      out_tready <= 0;
    end else if (hold_off > 0) begin
      hold_off--;
      out_tready <= 0;
    end else if (out_seen != n_out) begin
      out_seen = n_out;
      out_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 11) : 0;
      out_tready <= out_gap == 0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= out_gap == 0;
    end else out_tready <= 1;
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_tvalid && cfg_tready) || !rst_n || hold_off > 0)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_tvalid <= 1;
    do @(posedge clk); while (!cfg_tready);
    @(negedge clk);
    cfg_tvalid <= 0;
    if (idx == REG_BLOCK_SIZE) blk_edge = 32'(val);
    else if (idx == REG_TILE_WIDTH) tw = 32'(val);
    else if (idx == REG_TILE_HEIGHT) th = 32'(val);
  endtask

  task automatic drain;
    while (pixel_q.size() != 0 || in_tvalid || mean_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_tile(int bs, int w, int h);
    drain();
    write_reg(REG_BLOCK_SIZE, bs[8:0]);
    write_reg(REG_TILE_WIDTH, w[8:0]);
    write_reg(REG_TILE_HEIGHT, h[8:0]);
  endtask

  function automatic pixel_t rnd_pixel(int x, int y);
    pixel_t p;
    p.x = x[7:0];
    p.y = y[7:0];
    p.red = 8'($urandom);
    p.green = 8'($urandom);
    p.blue = 8'($urandom);
    return p;
  endfunction

  // raster scan of a w x h tile with some noise and dropped pixels
  task automatic queue_tile(int w, int h, int noise);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        if (noise != 0 && $urandom_range(0, 99) < noise) begin
          enq_pixel(rnd_pixel($urandom_range(0, 255), $urandom_range(0, 255)));
          if ($urandom_range(0, 1)) continue;
        end
        enq_pixel(rnd_pixel(x, y));
      end
  endtask

  initial begin
    pixel_t p;
    blk_edge = 8;
    tw = 256;
    th = 256;
    foreach (sum_r[i]) begin
      sum_r[i] = 0;
      sum_g[i] = 0;
      sum_b[i] = 0;
      px_cnt[i] = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // reset tile: corner pixels and the last pixel of the first block
    p = '1;
    enq_pixel(p);
    p = '0;
    enq_pixel(p);
    p = {8'hFF, 8'h00, 8'hFF, 8'd7, 8'd7};
    enq_pixel(p);
    // zero sizes act as one: the pixel at the origin emits, the next is outside the tile
    set_tile(0, 0, 0);
    p = {8'h12, 8'h34, 8'h56, 8'd0, 8'd0};
    enq_pixel(p);
    p = {8'h12, 8'h34, 8'h56, 8'd1, 8'd0};
    enq_pixel(p);
    // oversized block, clipped at the edges of a small tile; one pixel outside
    set_tile(511, 3, 2);
    queue_tile(3, 2, 0);
    enq_pixel(rnd_pixel(3, 0));
    // repeated pixels in one column of a single tile-sized block
    set_tile(256, 511, 511);
    for (int i = 0; i < 6; i++) begin
      p = '1;
      p.x = 0;
      p.y = 0;
      enq_pixel(p);
    end
    p = '1;
    enq_pixel(p);

    // stall the output while pixels keep coming
    set_tile(1, 4, 4);
    stall_go = 1;
    queue_tile(4, 4, 0);
    set_tile(2, 5, 3);
    queue_tile(5, 3, 0);

    while (n_pix < 520) begin
      int bs, w, h;
      bs = $urandom_range(0, 3) == 0 ? $urandom_range(0, 511) : $urandom_range(1, 4);
      w = $urandom_range(0, 5) == 0 ? $urandom_range(0, 511) : $urandom_range(1, 9);
      h = $urandom_range(0, 5) == 0 ? $urandom_range(0, 511) : $urandom_range(1, 6);
      if (eff_edge(w) * eff_edge(h) > 64) begin
        w = $urandom_range(1, 9);
        h = $urandom_range(1, 6);
      end
      set_tile(bs, w, h);
      queue_tile(eff_edge(w), eff_edge(h), $urandom_range(0, 1) ? 0 : 10);
    end
    drain();

    $display("pixels %0d, blocks %0d (%0d last-of-tile), over many tile and block sizes",
             n_pix, n_blocks, n_last);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
